// ===== hw/rtl/tlnd_pkg.sv =====
// shared types and codes for the two-level name directory
`default_nettype none

package tlnd_pkg;

  // name is ninth character over the first eight
  localparam int NAME_W = 72;
  localparam int SLOT_W = 4;

  // request operations
  localparam logic [1:0] FUNC_MKDIR  = 2'd0;
  localparam logic [1:0] FUNC_MKFILE = 2'd1;
  localparam logic [1:0] FUNC_RMFILE = 2'd2;
  localparam logic [1:0] FUNC_FIND   = 2'd3;

  // response status codes
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_NO_DIR  = 3'd2;
  localparam logic [2:0] ST_NO_FILE = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] dir_name_low;
    logic [7:0]  dir_name_high;
    logic [63:0] file_name_low;
    logic [7:0]  file_name_high;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] dir_slot;
    logic [SLOT_W-1:0] file_slot;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlnd_name_ram.sv =====
// single-port-write, single-port-read name ram with registered read data
`default_nettype none

module tlnd_name_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 72,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tlnd_ctrl.sv =====
// sequencer: name scans, counts and ram updates for each transaction
`default_nettype none

module tlnd_ctrl #(
  parameter int MAX_DIRS  = 16,
  parameter int MAX_FILES = 16,
  localparam int DIDX_W  = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1,
  localparam int FADDR_W = (MAX_DIRS * MAX_FILES > 1) ? $clog2(MAX_DIRS * MAX_FILES) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire tlnd_pkg::req_t              req,
  output logic                             res_valid,
  input  wire logic                        res_take,
  output tlnd_pkg::rsp_t                   res,
  output logic                             dir_wr_en,
  output logic [DIDX_W-1:0]                dir_wr_addr,
  output logic [tlnd_pkg::NAME_W-1:0]      dir_wr_data,
  output logic [DIDX_W-1:0]                dir_rd_addr,
  input  wire logic [tlnd_pkg::NAME_W-1:0] dir_rd_data,
  output logic                             file_wr_en,
  output logic [FADDR_W-1:0]               file_wr_addr,
  output logic [tlnd_pkg::NAME_W-1:0]      file_wr_data,
  output logic [FADDR_W-1:0]               file_rd_addr,
  input  wire logic [tlnd_pkg::NAME_W-1:0] file_rd_data
);

  localparam int DCNT_W = $clog2(MAX_DIRS + 1);
  localparam int FCNT_W = $clog2(MAX_FILES + 1);
  localparam int FIDX_W = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int CNT_W  = (DCNT_W > FCNT_W) ? DCNT_W : FCNT_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DSCAN  = 6'b000010,
    S_FSCAN  = 6'b000100,
    S_LAST   = 6'b001000,
    S_MOVE   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t                          state;
  tlnd_pkg::req_t                  req_q;
  logic [CNT_W-1:0]                idx;
  logic [CNT_W-1:0]                cmp_idx;
  logic                            cmp_valid;
  logic [DCNT_W-1:0]               dir_cnt;
  logic [FCNT_W-1:0]               files_cnt [MAX_DIRS];
  logic [DIDX_W-1:0]               cur_dir;
  logic [FADDR_W-1:0]              file_base;
  logic [FCNT_W-1:0]               file_cnt;
  logic [FIDX_W-1:0]               file_hit;
  logic [tlnd_pkg::NAME_W-1:0]     dir_name;
  logic [tlnd_pkg::NAME_W-1:0]     file_name;
  logic                            dir_match;
  logic                            file_match;
  logic                            dir_more;
  logic                            file_more;
  logic                            dir_full;
  logic                            file_full;
  logic                            mkdir_ok;
  logic                            mkfile_ok;

  assign dir_name  = {req_q.dir_name_high, req_q.dir_name_low};
  assign file_name = {req_q.file_name_high, req_q.file_name_low};

  // scan compare against the entry read in the previous cycle
  assign dir_match  = cmp_valid && (dir_rd_data == dir_name);
  assign file_match = cmp_valid && (file_rd_data == file_name);
  assign dir_more   = idx < CNT_W'(dir_cnt);
  assign file_more  = idx < CNT_W'(file_cnt);
  assign dir_full   = dir_cnt == DCNT_W'(MAX_DIRS);
  assign file_full  = file_cnt == FCNT_W'(MAX_FILES);

  assign mkdir_ok  = (state == S_DSCAN) && !dir_match && !dir_more &&
                     (req_q.func == tlnd_pkg::FUNC_MKDIR) && !dir_full;
  assign mkfile_ok = (state == S_FSCAN) && !file_match && !file_more &&
                     (req_q.func == tlnd_pkg::FUNC_MKFILE) && !file_full;

  // handshake
  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_RESULT);

  // directory ram ports
  assign dir_rd_addr = DIDX_W'(idx);
  assign dir_wr_en   = mkdir_ok;
  assign dir_wr_addr = DIDX_W'(dir_cnt);
  assign dir_wr_data = dir_name;

  // file ram ports: scan, fetch of the last file, append or move
  always_comb begin
    if (state == S_LAST) begin
      file_rd_addr = file_base + FADDR_W'(file_cnt) - FADDR_W'(1);
    end else begin
      file_rd_addr = file_base + FADDR_W'(idx);
    end
    if (state == S_MOVE) begin
      file_wr_en   = 1'b1;
      file_wr_addr = file_base + FADDR_W'(file_hit);
      file_wr_data = file_rd_data;
    end else begin
      file_wr_en   = mkfile_ok;
      file_wr_addr = file_base + FADDR_W'(file_cnt);
      file_wr_data = file_name;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmp_valid <= 1'b0;
      dir_cnt   <= '0;
      for (int i = 0; i < MAX_DIRS; i++) begin
        files_cnt[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q     <= req;
            idx       <= '0;
            cmp_valid <= 1'b0;
            state     <= S_DSCAN;
          end
        end
        S_DSCAN: begin
          if (dir_match) begin
            if (req_q.func == tlnd_pkg::FUNC_MKDIR) begin
              res   <= '{tlnd_pkg::ST_DUP, tlnd_pkg::SLOT_W'(cmp_idx), '0};
              state <= S_RESULT;
            end else begin
              cur_dir   <= DIDX_W'(cmp_idx);
              file_base <= FADDR_W'(cmp_idx) * FADDR_W'(MAX_FILES);
              file_cnt  <= files_cnt[DIDX_W'(cmp_idx)];
              idx       <= '0;
              cmp_valid <= 1'b0;
              state     <= S_FSCAN;
            end
          end else if (dir_more) begin
            cmp_idx   <= idx;
            cmp_valid <= 1'b1;
            idx       <= idx + CNT_W'(1);
          end else begin
            // directory not present
            if (req_q.func == tlnd_pkg::FUNC_MKDIR) begin
              if (dir_full) begin
                res <= '{tlnd_pkg::ST_FULL, '0, '0};
              end else begin
                res <= '{tlnd_pkg::ST_DONE, tlnd_pkg::SLOT_W'(dir_cnt), '0};
                files_cnt[DIDX_W'(dir_cnt)] <= '0;
                dir_cnt <= dir_cnt + DCNT_W'(1);
              end
            end else begin
              res <= '{tlnd_pkg::ST_NO_DIR, '0, '0};
            end
            state <= S_RESULT;
          end
        end
        S_FSCAN: begin
          if (file_match) begin
            case (req_q.func)
              tlnd_pkg::FUNC_MKFILE: begin
                res   <= '{tlnd_pkg::ST_DUP, tlnd_pkg::SLOT_W'(cur_dir),
                           tlnd_pkg::SLOT_W'(cmp_idx)};
                state <= S_RESULT;
              end
              tlnd_pkg::FUNC_RMFILE: begin
                res      <= '{tlnd_pkg::ST_DONE, tlnd_pkg::SLOT_W'(cur_dir),
                              tlnd_pkg::SLOT_W'(cmp_idx)};
                file_hit <= FIDX_W'(cmp_idx);
                state    <= S_LAST;
              end
              default: begin
                res   <= '{tlnd_pkg::ST_DONE, tlnd_pkg::SLOT_W'(cur_dir),
                           tlnd_pkg::SLOT_W'(cmp_idx)};
                state <= S_RESULT;
              end
            endcase
          end else if (file_more) begin
            cmp_idx   <= idx;
            cmp_valid <= 1'b1;
            idx       <= idx + CNT_W'(1);
          end else begin
            // file not present
            if (req_q.func == tlnd_pkg::FUNC_MKFILE) begin
              if (file_full) begin
                res <= '{tlnd_pkg::ST_FULL, tlnd_pkg::SLOT_W'(cur_dir), '0};
              end else begin
                res <= '{tlnd_pkg::ST_DONE, tlnd_pkg::SLOT_W'(cur_dir),
                         tlnd_pkg::SLOT_W'(file_cnt)};
                files_cnt[cur_dir] <= file_cnt + FCNT_W'(1);
              end
            end else begin
              res <= '{tlnd_pkg::ST_NO_FILE, tlnd_pkg::SLOT_W'(cur_dir), '0};
            end
            state <= S_RESULT;
          end
        end
        S_LAST: begin
          // read of the last file is in flight
          state <= S_MOVE;
        end
        S_MOVE: begin
          files_cnt[cur_dir] <= file_cnt - FCNT_W'(1);
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/two_level_name_directory.sv =====
// Two-level name directory: directories of uniquely named files.
// Request channel (req_valid / req_stall / req): one transaction per
// operation - create directory, create file, delete file, search file.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one transaction
// per request with a status and the directory and file slots touched.
// One request is processed at a time. The directory names are scanned
// one per cycle through the read port of the directory ram, then the
// names of the matched directory through the file ram, one per cycle.
// The response follows the directory scan and, for file operations, the
// scan of that directory's files; the read data of each ram is registered.
// A delete then fetches the last file (S_LAST) and moves it into the freed
// slot (S_MOVE). The next request is taken the cycle after the response
// enters the output register, even while stalled.
// Reset empties the directory table and all file counts; the name rams
// are not cleared and entries beyond the counts are never read.
// A stalled response holds its value; the next finished response waits
// inside the block until the output register frees up.
`default_nettype none

module two_level_name_directory #(
  parameter int MAX_DIRS  = 16,
  parameter int MAX_FILES = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire tlnd_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output tlnd_pkg::rsp_t      rsp
);

  localparam int DIDX_W  = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
  localparam int FADDR_W = (MAX_DIRS * MAX_FILES > 1) ? $clog2(MAX_DIRS * MAX_FILES) : 1;

  logic                        res_valid;
  logic                        res_take;
  tlnd_pkg::rsp_t              res;
  logic                        dir_wr_en;
  logic [DIDX_W-1:0]           dir_wr_addr;
  logic [tlnd_pkg::NAME_W-1:0] dir_wr_data;
  logic [DIDX_W-1:0]           dir_rd_addr;
  logic [tlnd_pkg::NAME_W-1:0] dir_rd_data;
  logic                        file_wr_en;
  logic [FADDR_W-1:0]          file_wr_addr;
  logic [tlnd_pkg::NAME_W-1:0] file_wr_data;
  logic [FADDR_W-1:0]          file_rd_addr;
  logic [tlnd_pkg::NAME_W-1:0] file_rd_data;

  tlnd_ctrl #(
    .MAX_DIRS  (MAX_DIRS),
    .MAX_FILES (MAX_FILES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res),
    .dir_wr_en    (dir_wr_en),
    .dir_wr_addr  (dir_wr_addr),
    .dir_wr_data  (dir_wr_data),
    .dir_rd_addr  (dir_rd_addr),
    .dir_rd_data  (dir_rd_data),
    .file_wr_en   (file_wr_en),
    .file_wr_addr (file_wr_addr),
    .file_wr_data (file_wr_data),
    .file_rd_addr (file_rd_addr),
    .file_rd_data (file_rd_data)
  );

  // directory names
  tlnd_name_ram #(
    .DEPTH (MAX_DIRS),
    .WIDTH (tlnd_pkg::NAME_W)
  ) u_dir_ram (
    .clk     (clk),
    .wr_en   (dir_wr_en),
    .wr_addr (dir_wr_addr),
    .wr_data (dir_wr_data),
    .rd_addr (dir_rd_addr),
    .rd_data (dir_rd_data)
  );

  // file names, one row of MAX_FILES per directory
  tlnd_name_ram #(
    .DEPTH (MAX_DIRS * MAX_FILES),
    .WIDTH (tlnd_pkg::NAME_W)
  ) u_file_ram (
    .clk     (clk),
    .wr_en   (file_wr_en),
    .wr_addr (file_wr_addr),
    .wr_data (file_wr_data),
    .rd_addr (file_rd_addr),
    .rd_data (file_rd_data)
  );

  // output register
  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// self-checking testbench for the two-level name directory
`timescale 1ns / 1ps

module tb;

  localparam int MAX_DIRS = 16;
  localparam int MAX_FILES = 16;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int POOL_SIZE = 20;

  typedef logic [tlnd_pkg::NAME_W-1:0] name_t;
  typedef enum int unsigned {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  tlnd_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  tlnd_pkg::rsp_t rsp;

  // directory contents as seen by the predictor
  name_t dir_names [MAX_DIRS];
  name_t file_names [MAX_DIRS][MAX_FILES];
  int unsigned file_count [MAX_DIRS];
  int unsigned dir_count = 0;

  tlnd_pkg::rsp_t awaited_rsp [$];
  tlnd_pkg::rsp_t want_rsp;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  name_t dir_pool [POOL_SIZE];
  name_t file_pool [POOL_SIZE];

  two_level_name_directory #(
    .MAX_DIRS(MAX_DIRS),
    .MAX_FILES(MAX_FILES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d responses outstanding", $time, awaited_rsp.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // response stall pattern, switching between modes at random intervals
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(3));
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE: rsp_stall <= 1'b0;
      STALL_LIGHT: rsp_stall <= ($urandom_range(99) < 30);
      STALL_HEAVY: rsp_stall <= ($urandom_range(99) < 60);
      default: rsp_stall <= (stall_tick % 4 != 0);
    endcase
  end

  // applies one request to the directory copy and returns the response it owes
  function automatic tlnd_pkg::rsp_t directory_update(input tlnd_pkg::req_t r);
    name_t dname;
    name_t fname;
    int d;
    int f;
    int unsigned last;
    tlnd_pkg::rsp_t o;
    dname = {r.dir_name_high, r.dir_name_low};
    fname = {r.file_name_high, r.file_name_low};
    o.status = tlnd_pkg::ST_DONE;
    o.dir_slot = '0;
    o.file_slot = '0;
    d = -1;
    f = -1;
    for (int i = 0; i < int'(dir_count); i++) begin
      if (d < 0 && dir_names[i] == dname) d = i;
    end
    if (r.func == tlnd_pkg::FUNC_MKDIR) begin
      if (d >= 0) begin
        o.status = tlnd_pkg::ST_DUP;
        o.dir_slot = tlnd_pkg::SLOT_W'(d);
      end else if (dir_count >= MAX_DIRS) begin
        o.status = tlnd_pkg::ST_FULL;
      end else begin
        o.dir_slot = tlnd_pkg::SLOT_W'(dir_count);
        dir_names[dir_count] = dname;
        file_count[dir_count] = 0;
        dir_count++;
      end
    end else if (d < 0) begin
      o.status = tlnd_pkg::ST_NO_DIR;
    end else begin
      o.dir_slot = tlnd_pkg::SLOT_W'(d);
      for (int j = 0; j < int'(file_count[d]); j++) begin
        if (f < 0 && file_names[d][j] == fname) f = j;
      end
      if (r.func == tlnd_pkg::FUNC_MKFILE) begin
        if (f >= 0) begin
          o.status = tlnd_pkg::ST_DUP;
          o.file_slot = tlnd_pkg::SLOT_W'(f);
        end else if (file_count[d] >= MAX_FILES) begin
          o.status = tlnd_pkg::ST_FULL;
        end else begin
          o.file_slot = tlnd_pkg::SLOT_W'(file_count[d]);
          file_names[d][file_count[d]] = fname;
          file_count[d]++;
        end
      end else if (f < 0) begin
        o.status = tlnd_pkg::ST_NO_FILE;
      end else begin
        o.file_slot = tlnd_pkg::SLOT_W'(f);
        // delete: the last file fills the freed slot
        if (r.func == tlnd_pkg::FUNC_RMFILE) begin
          last = file_count[d] - 1;
          file_names[d][f] = file_names[d][last];
          file_count[d] = last;
        end
      end
    end
    return o;
  endfunction

  function automatic name_t rand_name();
    return {8'($urandom), $urandom, $urandom};
  endfunction

  function automatic tlnd_pkg::req_t compose_req(input logic [1:0] func, input name_t dname,
                                                 input name_t fname);
    tlnd_pkg::req_t r;
    r.func = func;
    {r.dir_name_high, r.dir_name_low} = dname;
    {r.file_name_high, r.file_name_low} = fname;
    return r;
  endfunction

  // one request transaction, with bursts and random gaps between them
  task automatic send_req(input tlnd_pkg::req_t r);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    awaited_rsp.push_back(directory_update(r));
  endtask

  // hold off new requests until every response is back
  task automatic wait_drained();
    if (req_valid) req_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // response checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_rsp.size() == 0) begin
        $display("%0t: unexpected response status %0d dir_slot %0d file_slot %0d",
                 $time, rsp.status, rsp.dir_slot, rsp.file_slot);
        mismatch_count++;
      end else begin
        want_rsp = awaited_rsp.pop_front();
        check_field("status", 32'(want_rsp.status), 32'(rsp.status));
        check_field("dir_slot", 32'(want_rsp.dir_slot), 32'(rsp.dir_slot));
        check_field("file_slot", 32'(want_rsp.file_slot), 32'(rsp.file_slot));
      end
    end
  end

  // directory creation, duplicate, names that differ only in the ninth character
  task automatic test_dir_create();
    wait_drained();
    send_req(compose_req(tlnd_pkg::FUNC_MKDIR, dir_pool[0], rand_name()));
    send_req(compose_req(tlnd_pkg::FUNC_MKDIR, dir_pool[1], rand_name()));
    send_req(compose_req(tlnd_pkg::FUNC_MKDIR, dir_pool[0], rand_name()));
    send_req(compose_req(tlnd_pkg::FUNC_MKDIR, dir_pool[2], rand_name()));
  endtask

  // file operations on a directory that does not exist
  task automatic test_dir_missing();
    wait_drained();
    send_req(compose_req(tlnd_pkg::FUNC_MKFILE, dir_pool[3], file_pool[0]));
    send_req(compose_req(tlnd_pkg::FUNC_RMFILE, dir_pool[3], file_pool[0]));
    send_req(compose_req(tlnd_pkg::FUNC_FIND, dir_pool[3], file_pool[0]));
  endtask

  // create, duplicate, search, delete from the start and the end, missing file
  task automatic test_file_ops();
    wait_drained();
    send_req(compose_req(tlnd_pkg::FUNC_MKFILE, dir_pool[1], file_pool[0]));
    send_req(compose_req(tlnd_pkg::FUNC_MKFILE, dir_pool[1], file_pool[1]));
    send_req(compose_req(tlnd_pkg::FUNC_MKFILE, dir_pool[1], file_pool[2]));
    send_req(compose_req(tlnd_pkg::FUNC_MKFILE, dir_pool[1], file_pool[1]));
    send_req(compose_req(tlnd_pkg::FUNC_FIND, dir_pool[1], file_pool[2]));
    send_req(compose_req(tlnd_pkg::FUNC_FIND, dir_pool[1], file_pool[3]));
    send_req(compose_req(tlnd_pkg::FUNC_RMFILE, dir_pool[1], file_pool[0]));
    send_req(compose_req(tlnd_pkg::FUNC_FIND, dir_pool[1], file_pool[2]));
    send_req(compose_req(tlnd_pkg::FUNC_RMFILE, dir_pool[1], file_pool[1]));
    send_req(compose_req(tlnd_pkg::FUNC_RMFILE, dir_pool[1], file_pool[3]));
    send_req(compose_req(tlnd_pkg::FUNC_FIND, dir_pool[1], file_pool[0]));
  endtask

  // fill one directory and go one past its capacity
  task automatic test_file_full();
    wait_drained();
    for (int i = 0; i <= MAX_FILES; i++) begin
      send_req(compose_req(tlnd_pkg::FUNC_MKFILE, dir_pool[0], file_pool[i]));
    end
  endtask

  // mostly well-formed traffic over small name pools, with some noise
  task automatic test_random_mix(input int unsigned count);
    tlnd_pkg::req_t r;
    int unsigned sel;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 300 == 299) wait_drained();
      sel = $urandom_range(99);
      if (sel < 8) begin
        r = compose_req(2'($urandom_range(3)), rand_name(), rand_name());
      end else begin
        sel = $urandom_range(99);
        r.func = (sel < 10) ? tlnd_pkg::FUNC_MKDIR : (sel < 50) ? tlnd_pkg::FUNC_MKFILE :
                 (sel < 70) ? tlnd_pkg::FUNC_RMFILE : tlnd_pkg::FUNC_FIND;
        {r.dir_name_high, r.dir_name_low} = ($urandom_range(99) < 5) ? rand_name() :
            dir_pool[$urandom_range(POOL_SIZE - 1)];
        {r.file_name_high, r.file_name_low} = ($urandom_range(99) < 10) ? rand_name() :
            file_pool[$urandom_range(POOL_SIZE - 1)];
      end
      send_req(r);
    end
  endtask

  // top up the directory table, then overflow it and repeat a known name
  task automatic test_dir_table_full();
    wait_drained();
    while (dir_count < MAX_DIRS) begin
      send_req(compose_req(tlnd_pkg::FUNC_MKDIR, rand_name(), rand_name()));
    end
    send_req(compose_req(tlnd_pkg::FUNC_MKDIR, rand_name(), rand_name()));
    send_req(compose_req(tlnd_pkg::FUNC_MKDIR, dir_pool[0], rand_name()));
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      dir_pool[i] = rand_name();
      file_pool[i] = rand_name();
    end
    // extreme names, and one set only in the ninth character
    dir_pool[0] = '0;
    dir_pool[1] = '1;
    dir_pool[2] = {8'h01, 64'h0};
    file_pool[0] = '0;
    file_pool[1] = '1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_dir_create();
    test_dir_missing();
    test_file_ops();
    test_file_full();
    test_random_mix(1150);
    test_dir_table_full();
    wait_drained();
    repeat (MAX_DIRS + MAX_FILES + 12) @(posedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
